// File: rtl/core/fgbh_pkg.sv
// Package for the folded global branch history unit.
// Holds field widths, codes, controller state and command/status types.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package fgbh_pkg;

    localparam int WORD_BITS         = 64;
    localparam int DEF_MAX_HIST_BITS = 1024;
    localparam int CFG_W             = 11;
    localparam int FLEN_W            = 11;
    localparam int FWID_W            = 7;
    localparam int OUT_W             = 64;

    localparam logic [CFG_W-1:0]  TOTAL_LEN_RESET = 11'd1024;
    localparam logic [FWID_W-1:0] FWID_MAX        = 7'd64;

    localparam logic MODE_UPDATE = 1'b0;
    localparam logic MODE_QUERY  = 1'b1;

    typedef enum logic [1:0] {
        S_IDLE,
        S_FOLD
    } t_ctrl_state;

    typedef struct packed {
        logic shift;
        logic load;
        logic step;
        logic publish;
    } t_dp_cmd;

    typedef struct packed {
        logic rem_zero;
    } t_dp_status;

endpackage
`default_nettype wire

// File: rtl/core/fgbh_if.sv
// Channel interfaces for the folded global branch history unit.
// Depends on fgbh_pkg for the field widths.
`timescale 1ns / 1ps
`default_nettype none
interface fgbh_in_if;
    import fgbh_pkg::*;

    logic              valid;
    logic              ready;
    logic              mode;
    logic              taken;
    logic [FLEN_W-1:0] fold_length;
    logic [FWID_W-1:0] fold_width;

    modport source (output valid, mode, taken, fold_length, fold_width, input ready);
    modport sink   (input valid, mode, taken, fold_length, fold_width, output ready);
endinterface

interface fgbh_out_if;
    import fgbh_pkg::*;

    logic             valid;
    logic             ready;
    logic [OUT_W-1:0] recent_history;
    logic [OUT_W-1:0] folded;

    modport source (output valid, recent_history, folded, input ready);
    modport sink   (input valid, recent_history, folded, output ready);
endinterface
`default_nettype wire

// File: rtl/core/fgbh_ctrl.sv
// Controller for the folded global branch history unit.
// Sequences updates and fold queries and owns the result valid flag; uses fgbh_pkg.
`timescale 1ns / 1ps
`default_nettype none
module fgbh_ctrl (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_in_valid,
    input  wire                  i_in_mode,
    output logic                 o_in_ready,
    output logic                 o_out_valid,
    input  wire                  i_out_ready,
    output fgbh_pkg::t_dp_cmd    o_cmd,
    input  fgbh_pkg::t_dp_status i_status
);
    import fgbh_pkg::*;

    t_ctrl_state r_state;
    t_ctrl_state n_state;
    logic        r_out_valid;
    logic        n_out_valid;
    logic        accept;
    logic        out_free;

    assign accept   = i_in_valid && o_in_ready;
    assign out_free = !r_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid && !i_out_ready;
        o_in_ready  = 1'b0;
        o_cmd       = '0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (accept) begin
                    if (i_in_mode == MODE_QUERY) begin
                        o_cmd.load = 1'b1;
                        n_state    = S_FOLD;
                    end else begin
                        o_cmd.shift = 1'b1;
                    end
                end
            end
            S_FOLD: begin
                if (!i_status.rem_zero) begin
                    o_cmd.step = 1'b1;
                end else if (out_free) begin
                    o_cmd.publish = 1'b1;
                    n_out_valid   = 1'b1;
                    n_state       = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_out_valid = r_out_valid;

endmodule
`default_nettype wire

// File: rtl/core/fgbh_dp.sv
// Datapath for the folded global branch history unit.
// History shift register, fold shifter and accumulator, config and result registers.
// Uses fgbh_pkg.
`timescale 1ns / 1ps
`default_nettype none
module fgbh_dp #(
    parameter int MAX_HIST_BITS = fgbh_pkg::DEF_MAX_HIST_BITS
) (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire                          i_cfg_wr_en,
    input  wire  [fgbh_pkg::CFG_W-1:0]   i_cfg_wr_data,
    input  fgbh_pkg::t_dp_cmd            i_cmd,
    output fgbh_pkg::t_dp_status         o_status,
    input  wire                          i_taken,
    input  wire  [fgbh_pkg::FLEN_W-1:0]  i_fold_length,
    input  wire  [fgbh_pkg::FWID_W-1:0]  i_fold_width,
    output logic [fgbh_pkg::OUT_W-1:0]   o_recent_history,
    output logic [fgbh_pkg::OUT_W-1:0]   o_folded
);
    import fgbh_pkg::*;

    localparam int MAX_WORDS = (MAX_HIST_BITS + WORD_BITS - 1) / WORD_BITS;
    localparam int HIST_BITS = MAX_WORDS * WORD_BITS;
    localparam int SPAN_W    = $clog2(HIST_BITS + 1);
    localparam int CMP_W     = (SPAN_W > FLEN_W) ? SPAN_W : FLEN_W;

    logic [CFG_W-1:0]     r_total_length;
    logic [HIST_BITS-1:0] r_hist;
    logic [HIST_BITS-1:0] r_work;
    logic [OUT_W-1:0]     r_acc;
    logic [FLEN_W-1:0]    r_rem;
    logic [FWID_W-1:0]    r_width;
    logic [OUT_W-1:0]     r_recent;
    logic [OUT_W-1:0]     r_folded;

    logic [CMP_W-1:0]     eff_len;
    logic [CMP_W:0]       span_sum;
    logic [CMP_W-1:0]     span_bits;
    logic [CMP_W-1:0]     flen_ext;
    logic [FLEN_W-1:0]    flen_clamped;
    logic [FWID_W-1:0]    width_clamped;
    logic [FWID_W-1:0]    take;
    logic [OUT_W-1:0]     slice_mask;
    logic [OUT_W-1:0]     recent_masked;

    always_comb begin
        eff_len = CMP_W'(r_total_length);
        if (eff_len == '0) begin
            eff_len = CMP_W'(1);
        end
        if (eff_len > CMP_W'(MAX_HIST_BITS)) begin
            eff_len = CMP_W'(MAX_HIST_BITS);
        end
        span_sum  = {1'b0, eff_len} + (CMP_W + 1)'(WORD_BITS - 1);
        span_bits = span_sum[CMP_W-1:0] & ~CMP_W'(WORD_BITS - 1);

        flen_ext = CMP_W'(i_fold_length);
        if (flen_ext > span_bits) begin
            flen_clamped = FLEN_W'(span_bits);
        end else begin
            flen_clamped = i_fold_length;
        end

        width_clamped = i_fold_width;
        if (width_clamped == '0) begin
            width_clamped = FWID_W'(1);
        end
        if (width_clamped > FWID_MAX) begin
            width_clamped = FWID_MAX;
        end

        if (FLEN_W'(r_width) > r_rem) begin
            take = FWID_W'(r_rem);
        end else begin
            take = r_width;
        end
        if (take >= FWID_MAX) begin
            slice_mask = '1;
        end else begin
            slice_mask = ~({OUT_W{1'b1}} << take[5:0]);
        end

        if (eff_len < CMP_W'(OUT_W)) begin
            recent_masked = r_hist[OUT_W-1:0] & ~({OUT_W{1'b1}} << eff_len[5:0]);
        end else begin
            recent_masked = r_hist[OUT_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_total_length <= TOTAL_LEN_RESET;
            r_hist         <= '0;
            r_rem          <= '0;
        end else if (i_cfg_wr_en) begin
            r_total_length <= i_cfg_wr_data;
            r_hist         <= '0;
            r_rem          <= '0;
        end else begin
            if (i_cmd.shift) begin
                r_hist <= {r_hist[HIST_BITS-2:0], i_taken};
            end
            if (i_cmd.load) begin
                r_rem <= flen_clamped;
            end else if (i_cmd.step) begin
                r_rem <= r_rem - FLEN_W'(take);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_work  <= r_hist;
            r_acc   <= '0;
            r_width <= width_clamped;
        end else if (i_cmd.step) begin
            r_work <= r_work >> r_width;
            r_acc  <= r_acc ^ (r_work[OUT_W-1:0] & slice_mask);
        end
        if (i_cmd.publish) begin
            r_recent <= recent_masked;
            r_folded <= r_acc;
        end
    end

    assign o_status.rem_zero = (r_rem == '0);
    assign o_recent_history  = r_recent;
    assign o_folded          = r_folded;

endmodule
`default_nettype wire

// File: rtl/core/folded_global_branch_history_unit.sv
// Top level of the folded global branch history unit.
// Joins fgbh_ctrl and fgbh_dp; depends on fgbh_pkg and the interfaces in fgbh_if.
//
//  Channel     Direction  Contents
//  i_item      in         mode, taken, fold_length, fold_width
//  o_result    out        recent_history, folded (one per query)
//  i_cfg_*     in         total_length write, one register
//
// An update shifts the taken bit into the history and the next item may follow at once.
// A query loads the fold shifter, which consumes one slice of up to fold_width bits
// a cycle until min(fold_length, span) bits are folded; the result is then published.
// The result register frees the input while a result waits; a query stalls in the
// fold state only when the previous result has not yet been taken.
// Reset is synchronous and clears the history; a configuration write does the same.
`timescale 1ns / 1ps
`default_nettype none
module folded_global_branch_history_unit #(
    parameter int MAX_HIST_BITS = fgbh_pkg::DEF_MAX_HIST_BITS
) (
    input  wire                        i_clk,
    input  wire                        i_rst_n,
    input  wire                        i_cfg_wr_en,
    input  wire  [fgbh_pkg::CFG_W-1:0] i_cfg_wr_data,
    fgbh_in_if.sink                    i_item,
    fgbh_out_if.source                 o_result
);
    import fgbh_pkg::*;

    t_dp_cmd    cmd;
    t_dp_status status;

    fgbh_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_item.valid),
        .i_in_mode   (i_item.mode),
        .o_in_ready  (i_item.ready),
        .o_out_valid (o_result.valid),
        .i_out_ready (o_result.ready),
        .o_cmd       (cmd),
        .i_status    (status)
    );

    fgbh_dp #(
        .MAX_HIST_BITS (MAX_HIST_BITS)
    ) u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_wr_en      (i_cfg_wr_en),
        .i_cfg_wr_data    (i_cfg_wr_data),
        .i_cmd            (cmd),
        .o_status         (status),
        .i_taken          (i_item.taken),
        .i_fold_length    (i_item.fold_length),
        .i_fold_width     (i_item.fold_width),
        .o_recent_history (o_result.recent_history),
        .o_folded         (o_result.folded)
    );

`ifndef SYNTH
    a_query_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_rst_n && i_item.valid && i_item.ready && i_item.mode == MODE_QUERY)
        |=> !i_item.ready)
        else $error("input still ready after a query transfer");

    a_update_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_rst_n && i_item.valid && i_item.ready && i_item.mode == MODE_UPDATE)
        |=> i_item.ready)
        else $error("update transfer did not complete in one cycle");

    a_result_from_fold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_result.valid) |-> $past(!i_item.ready))
        else $error("result raised without a query in progress");
`endif

endmodule
`default_nettype wire
